// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ftv_pkg.sv =====
// Types and character codes for the position-string validator.
// No dependencies; imported by ftv_in_stage, ftv_check and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ftv_pkg;

    typedef enum logic [2:0] {
        FLD_BOARD  = 3'd0,
        FLD_TURN   = 3'd1,
        FLD_CASTLE = 3'd2,
        FLD_EP     = 3'd3,
        FLD_HALF   = 3'd4,
        FLD_FULL   = 3'd5,
        FLD_TRAIL  = 3'd6
    } t_field;

    // One input word as held in the input register.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_word;

    // Verdict produced on the last byte of a string.
    typedef struct packed {
        logic fire;
        logic ok;
    } t_verdict;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_H_LO  = 8'h68;
    localparam logic [7:0] CH_W_LO  = 8'h77;
    localparam logic [7:0] CH_B_LO  = 8'h62;

    localparam logic [3:0] RANK_SQUARES = 4'd8;
    localparam logic [3:0] RANK_SAT     = 4'd9;
    localparam logic [3:0] BOARD_SLASHES = 4'd7;
    localparam logic [3:0] SLASH_SAT    = 4'd8;
    localparam logic [1:0] LEN_SAT      = 2'd3;

endpackage

`default_nettype wire

// ===== src/ftv_in_stage.sv =====
// Input register of the validator: captures one word per accepted handshake.
// Depends on ftv_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none

module ftv_in_stage
    import ftv_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    input  wire logic     i_drain,
    input  wire t_in_word i_word,
    output t_in_word      o_word,
    output logic          o_full
);

    logic     r_full;
    t_in_word r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_load) begin
            r_full <= 1'b1;
        end else if (i_drain) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_word = r_word;
    assign o_full = r_full;

endmodule

`default_nettype wire

// ===== src/ftv_check.sv =====
// Field checker: parse state and the per-byte update of all checks.
// Depends on ftv_pkg for field codes, character codes and the verdict type.
`timescale 1ns / 1ps
`default_nettype none

module ftv_check
    import ftv_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_in_word i_word,
    output t_verdict      o_verdict
);

    t_field     r_field, n_field;
    logic       r_failed, n_failed;
    logic [3:0] r_slash, n_slash;
    logic [3:0] r_rank, n_rank;
    logic [1:0] r_len, n_len;
    logic       r_tok_ok, n_tok_ok;
    logic       r_nz, n_nz;

    logic [7:0] c;
    logic       is_piece;
    logic       is_castle;
    logic       is_digit;
    logic       closed;
    logic       fail_end;
    logic [4:0] rank_add;
    logic [3:0] rank_sat;
    logic [3:0] squares;

    // Checks that apply when a field closes.
    function automatic logic close_fails(input t_field f, input logic [3:0] slash,
                                         input logic [3:0] rank, input logic [1:0] len,
                                         input logic tok, input logic nz);
        logic bad;
        bad = 1'b0;
        case (f)
            FLD_BOARD: bad = (slash != BOARD_SLASHES) || (rank != RANK_SQUARES);
            FLD_TURN:  bad = (len == 2'd0);
            FLD_EP:    bad = (len == 2'd0) || ((len == 2'd1) && tok);
            FLD_FULL:  bad = !nz;
            default:   bad = 1'b0;
        endcase
        return bad;
    endfunction

    assign c = i_word.text_byte;

    always_comb begin
        case (c)
            "r", "n", "b", "q", "k", "p", "R", "N", "B", "Q", "K", "P": is_piece = 1'b1;
            default: is_piece = 1'b0;
        endcase
    end

    assign is_castle = (c == "K") || (c == "Q") || (c == "k") || (c == "q");
    assign is_digit  = (c >= CH_0) && (c <= CH_9);
    assign squares   = ((c >= CH_1) && (c <= CH_8)) ? c[3:0] : 4'd1;
    assign rank_add  = {1'b0, r_rank} + {1'b0, squares};
    assign rank_sat  = (rank_add > {1'b0, RANK_SAT}) ? RANK_SAT : rank_add[3:0];

    always_comb begin
        n_field  = r_field;
        n_failed = r_failed;
        n_slash  = r_slash;
        n_rank   = r_rank;
        n_len    = r_len;
        n_tok_ok = r_tok_ok;
        n_nz     = r_nz;
        closed   = 1'b0;
        fail_end = 1'b0;
        o_verdict.fire = 1'b0;
        o_verdict.ok   = 1'b0;

        if (i_step) begin
            if ((c == CH_SPACE) && (r_field < FLD_TRAIL)) begin
                // Close the field and start the next one.
                closed = 1'b1;
                if (close_fails(r_field, r_slash, r_rank, r_len, r_tok_ok, r_nz)) begin
                    n_failed = 1'b1;
                end
                n_field  = t_field'(3'(r_field) + 3'd1);
                n_len    = 2'd0;
                n_tok_ok = 1'b1;
                n_nz     = 1'b0;
            end else begin
                case (r_field)
                    FLD_BOARD: begin
                        if (c == CH_SLASH) begin
                            if (r_rank != RANK_SQUARES) n_failed = 1'b1;
                            n_rank = 4'd0;
                            if (r_slash < SLASH_SAT) n_slash = r_slash + 4'd1;
                        end else if (((c >= CH_1) && (c <= CH_8)) || is_piece) begin
                            n_rank = rank_sat;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    FLD_TURN: begin
                        if ((r_len != 2'd0) || ((c != CH_W_LO) && (c != CH_B_LO)))
                            n_failed = 1'b1;
                    end
                    FLD_CASTLE: begin
                        if (r_len == 2'd0) begin
                            if (c == CH_DASH) n_tok_ok = 1'b0;
                            else if (!is_castle) n_failed = 1'b1;
                        end else if (!r_tok_ok || !is_castle) begin
                            n_failed = 1'b1;
                        end
                    end
                    FLD_EP: begin
                        if (r_len == 2'd0) begin
                            if (c == CH_DASH) n_tok_ok = 1'b0;
                            else if ((c >= CH_A_LO) && (c <= CH_H_LO)) n_tok_ok = 1'b1;
                            else n_failed = 1'b1;
                        end else if (r_len == 2'd1) begin
                            if (!r_tok_ok || ((c != CH_3) && (c != CH_6))) n_failed = 1'b1;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    FLD_HALF: begin
                        if (!is_digit) n_failed = 1'b1;
                    end
                    FLD_FULL: begin
                        if (!is_digit) n_failed = 1'b1;
                        else if (c != CH_0) n_nz = 1'b1;
                    end
                    default: ;
                endcase
                // Count the byte in every checked field after the board.
                if ((r_field != FLD_BOARD) && (r_field < FLD_TRAIL) && (r_len < LEN_SAT)) begin
                    n_len = r_len + 2'd1;
                end
            end

            if (i_word.last_byte) begin
                if (!closed && (n_field < FLD_TRAIL)) begin
                    fail_end = close_fails(n_field, n_slash, n_rank, n_len, n_tok_ok, n_nz);
                end
                o_verdict.fire = 1'b1;
                o_verdict.ok   = !(n_failed || fail_end);
                // Return to the start-of-string state.
                n_field  = FLD_BOARD;
                n_failed = 1'b0;
                n_slash  = 4'd0;
                n_rank   = 4'd0;
                n_len    = 2'd0;
                n_tok_ok = 1'b1;
                n_nz     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field  <= FLD_BOARD;
            r_failed <= 1'b0;
            r_slash  <= 4'd0;
            r_rank   <= 4'd0;
            r_len    <= 2'd0;
            r_tok_ok <= 1'b1;
            r_nz     <= 1'b0;
        end else begin
            r_field  <= n_field;
            r_failed <= n_failed;
            r_slash  <= n_slash;
            r_rank   <= n_rank;
            r_len    <= n_len;
            r_tok_ok <= n_tok_ok;
            r_nz     <= n_nz;
        end
    end

endmodule

`default_nettype wire

// ===== src/fen_text_validator_unit.sv =====
// Channel  | Direction | Handshake        | Payload
// ---------+-----------+------------------+--------------------------------
// input    | in        | i_valid/o_stall  | i_text_byte[7:0], i_last_byte
// result   | out       | o_valid/i_stall  | o_string_valid
//
// One word is accepted per cycle while o_stall is low; the last byte of a string
// sits in the input register, then the check logic loads the result into the
// output register. Only the last byte of a string produces a result word.
// Reset (i_rst_n low, synchronous) returns the parser to the board field.
// A stalled result holds the output register; non-last bytes keep flowing,
// and the input stalls only when a last byte waits behind a held result.
// Top level of the validator. Depends on ftv_pkg, ftv_in_stage and ftv_check.
`timescale 1ns / 1ps
`default_nettype none

module fen_text_validator_unit
    import ftv_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_last_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_string_valid
);

    t_in_word in_word;
    t_in_word held_word;
    logic     held_full;
    logic     out_blocked;
    logic     step;
    logic     load;
    t_verdict verdict;

    logic r_out_valid;
    logic r_out_ok;

    assign in_word.text_byte = i_text_byte;
    assign in_word.last_byte = i_last_byte;

    // Hold a last byte only while the previous result is still pending.
    assign out_blocked = r_out_valid && i_stall;
    assign step        = held_full && !(held_word.last_byte && out_blocked);
    assign o_stall     = held_full && !step;
    assign load        = i_valid && !o_stall;

    ftv_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_drain (step),
        .i_word  (in_word),
        .o_word  (held_word),
        .o_full  (held_full)
    );

    ftv_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_word    (held_word),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (verdict.fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (verdict.fire) begin
            r_out_ok <= verdict.ok;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_string_valid = r_out_ok;

endmodule

`default_nettype wire

// ===== src/ftv_checker.sv =====
// Port-level checks for the validator, bound to the top level.
// Depends on assert_macros.svh and fen_text_validator_unit.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ftv_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic o_string_valid
);

    `ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_string_valid), "result word changed while stalled")
    `ASSERT_NOW(a_stall_cause, o_stall, o_valid && i_stall, "input stalled without a held result word")
    `ASSERT_NOW(a_out_drop, $fell(o_valid), $past(!i_stall), "result word dropped without being taken")

endmodule

bind fen_text_validator_unit ftv_checker u_ftv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_string_valid (o_string_valid)
);

`default_nettype wire
